>>> hw/rtl/iohist_pkg.sv
`timescale 1ns / 1ps

package iohist_pkg;

    // Histogram geometry.
    localparam int NUM_BINS     = 461;
    localparam int BIN_W        = 9;
    localparam int OVERFLOW_BIN = 460;

    // Counter geometry; results report at most REPORT_W bits.
    localparam int COUNT_WIDTH = 32;
    localparam int REPORT_W    = 32;

    // Input and result widths.
    localparam int LEN_W       = 32;
    localparam int KIB_SHIFT   = 10;
    localparam int KIB_W       = LEN_W - KIB_SHIFT;
    localparam int MDATA_W     = 48;

    // Decade quotient by reciprocal multiplication.
    localparam int X_W         = 20;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam int DIV_W       = 14;
    localparam int Q_W         = 7;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int REM_W       = X_W + 1;

    // Range of the KiB value that decides how the bin is formed.
    typedef enum logic [2:0] {
        DEC_UNIT,
        DEC_TENS,
        DEC_HUNDREDS,
        DEC_THOUSANDS,
        DEC_TEN_THOUSANDS,
        DEC_OVER
    } dec_t;

    // One binned item handed to the counter.
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             count_it;
    } bin_item_t;

    // Truncated reciprocal 2^RECIP_SHIFT / divisor; the estimate is at most one low.
    function automatic logic [RECIP_W-1:0] dec_recip(input dec_t dec);
        logic [RECIP_W-1:0] r;
        unique case (dec)
            DEC_TENS:          r = RECIP_W'((1 << RECIP_SHIFT) / 10);
            DEC_HUNDREDS:      r = RECIP_W'((1 << RECIP_SHIFT) / 100);
            DEC_THOUSANDS:     r = RECIP_W'((1 << RECIP_SHIFT) / 1000);
            DEC_TEN_THOUSANDS: r = RECIP_W'((1 << RECIP_SHIFT) / 10000);
            default:           r = '0;
        endcase
        return r;
    endfunction

    // Width of one linear bin within the decade.
    function automatic logic [DIV_W-1:0] dec_divisor(input dec_t dec);
        logic [DIV_W-1:0] d;
        unique case (dec)
            DEC_TENS:          d = DIV_W'(10);
            DEC_HUNDREDS:      d = DIV_W'(100);
            DEC_THOUSANDS:     d = DIV_W'(1000);
            DEC_TEN_THOUSANDS: d = DIV_W'(10000);
            default:           d = DIV_W'(1);
        endcase
        return d;
    endfunction

    // Bin offset added to the quotient (10..99) within each decade.
    function automatic logic [BIN_W-1:0] dec_base(input dec_t dec);
        logic [BIN_W-1:0] b;
        unique case (dec)
            DEC_TENS:          b = BIN_W'(90);
            DEC_HUNDREDS:      b = BIN_W'(180);
            DEC_THOUSANDS:     b = BIN_W'(270);
            DEC_TEN_THOUSANDS: b = BIN_W'(360);
            default:           b = '0;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/iohist_binner.sv
`timescale 1ns / 1ps

module iohist_binner (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             in_length,
    input  logic                    in_known,
    output logic                    out_valid,
    input  logic                    out_ready,
    output iohist_pkg::bin_item_t   out_item
);

    // Stage valid bits.
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_load, b_load, c_load, d_load;

    // Stage A: decade and KiB value.
    iohist_pkg::dec_t                   a_dec_reg;
    logic [iohist_pkg::X_W-1:0]         a_x_reg;
    logic                               a_cnt_reg;
    iohist_pkg::dec_t                   a_dec_next;
    logic [iohist_pkg::KIB_W-1:0]       kib;

    // Stage B: reciprocal product.
    iohist_pkg::dec_t                   b_dec_reg;
    logic [iohist_pkg::X_W-1:0]         b_x_reg;
    logic                               b_cnt_reg;
    logic [iohist_pkg::PROD_W-1:0]      b_prod_reg;
    logic [iohist_pkg::PROD_W-1:0]      b_prod_next;

    // Stage C: quotient estimate and its correction flag.
    iohist_pkg::dec_t                   c_dec_reg;
    logic [iohist_pkg::Q_W-1:0]         c_q_reg;
    logic                               c_ge_reg;
    logic                               c_cnt_reg;
    logic [iohist_pkg::Q_W-1:0]         c_q_next;
    logic                               c_ge_next;
    logic [iohist_pkg::REM_W-1:0]       c_qd;
    logic [iohist_pkg::REM_W-1:0]       c_rem;

    // Stage D: final bin.
    logic [iohist_pkg::BIN_W-1:0]       d_bin_reg;
    logic                               d_cnt_reg;
    logic [iohist_pkg::BIN_W-1:0]       d_bin_next;

    // Elastic pipeline: a stage loads when empty or when it moves on.
    assign d_load   = !d_valid_reg || out_ready;
    assign c_load   = !c_valid_reg || d_load;
    assign b_load   = !b_valid_reg || c_load;
    assign a_load   = !a_valid_reg || b_load;
    assign in_ready = a_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_load) a_valid_reg <= in_valid;
            if (b_load) b_valid_reg <= a_valid_reg;
            if (c_load) c_valid_reg <= b_valid_reg;
            if (d_load) d_valid_reg <= c_valid_reg;
        end
    end

    // Classify the KiB length by decade.
    always_comb begin
        kib = in_length[iohist_pkg::LEN_W-1:iohist_pkg::KIB_SHIFT];
        if (kib < iohist_pkg::KIB_W'(100)) begin
            a_dec_next = iohist_pkg::DEC_UNIT;
        end else if (kib < iohist_pkg::KIB_W'(1000)) begin
            a_dec_next = iohist_pkg::DEC_TENS;
        end else if (kib < iohist_pkg::KIB_W'(10000)) begin
            a_dec_next = iohist_pkg::DEC_HUNDREDS;
        end else if (kib < iohist_pkg::KIB_W'(100000)) begin
            a_dec_next = iohist_pkg::DEC_THOUSANDS;
        end else if (kib < iohist_pkg::KIB_W'(1000000)) begin
            a_dec_next = iohist_pkg::DEC_TEN_THOUSANDS;
        end else begin
            a_dec_next = iohist_pkg::DEC_OVER;
        end
    end

    // Multiply by the decade's reciprocal.
    assign b_prod_next = iohist_pkg::PROD_W'(a_x_reg)
                       * iohist_pkg::PROD_W'(iohist_pkg::dec_recip(a_dec_reg));

    // The estimate is low by at most one; the remainder tells.
    always_comb begin
        c_q_next  = b_prod_reg[iohist_pkg::RECIP_SHIFT +: iohist_pkg::Q_W];
        c_qd      = iohist_pkg::REM_W'(c_q_next)
                  * iohist_pkg::REM_W'(iohist_pkg::dec_divisor(b_dec_reg));
        c_rem     = iohist_pkg::REM_W'(b_x_reg) - c_qd;
        c_ge_next = c_rem >= iohist_pkg::REM_W'(iohist_pkg::dec_divisor(b_dec_reg));
    end

    // Assemble the bin index.
    always_comb begin
        unique case (c_dec_reg)
            iohist_pkg::DEC_UNIT: begin
                d_bin_next = iohist_pkg::BIN_W'(c_q_reg);
            end
            iohist_pkg::DEC_OVER: begin
                d_bin_next = iohist_pkg::BIN_W'(iohist_pkg::OVERFLOW_BIN);
            end
            default: begin
                d_bin_next = iohist_pkg::dec_base(c_dec_reg)
                           + iohist_pkg::BIN_W'(c_q_reg)
                           + iohist_pkg::BIN_W'(c_ge_reg);
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_load && in_valid) begin
            a_dec_reg <= a_dec_next;
            a_x_reg   <= kib[iohist_pkg::X_W-1:0];
            a_cnt_reg <= in_known && (in_length != '0);
        end
        if (b_load && a_valid_reg) begin
            b_dec_reg  <= a_dec_reg;
            b_x_reg    <= a_x_reg;
            b_cnt_reg  <= a_cnt_reg;
            b_prod_reg <= b_prod_next;
        end
        if (c_load && b_valid_reg) begin
            c_dec_reg <= b_dec_reg;
            c_cnt_reg <= b_cnt_reg;
            c_ge_reg  <= c_ge_next;
            // Small values bypass the divider and use the KiB value itself.
            if (b_dec_reg == iohist_pkg::DEC_UNIT) begin
                c_q_reg <= b_x_reg[iohist_pkg::Q_W-1:0];
            end else begin
                c_q_reg <= c_q_next;
            end
        end
        if (d_load && c_valid_reg) begin
            d_bin_reg <= d_bin_next;
            d_cnt_reg <= c_cnt_reg;
        end
    end

    assign out_valid         = d_valid_reg;
    assign out_item.bin      = d_bin_reg;
    assign out_item.count_it = d_cnt_reg;

endmodule

>>> hw/rtl/iohist_counter.sv
`timescale 1ns / 1ps

module iohist_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  iohist_pkg::bin_item_t               in_item,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_counted,
    output logic [iohist_pkg::BIN_W-1:0]        out_bin,
    output logic [iohist_pkg::REPORT_W-1:0]     out_count
);

    // Bin counter store.
    logic [iohist_pkg::COUNT_WIDTH-1:0] mem [iohist_pkg::NUM_BINS];
    logic [iohist_pkg::COUNT_WIDTH-1:0] rd_data_reg;

    // Clearing pass after reset.
    logic                               clearing_reg;
    logic [iohist_pkg::BIN_W-1:0]       clr_addr_reg;

    // Read-modify-write stage.
    logic                               e_valid_reg;
    logic [iohist_pkg::BIN_W-1:0]       e_bin_reg;
    logic                               e_cnt_reg;
    logic                               e_fwd_reg;
    logic [iohist_pkg::COUNT_WIDTH-1:0] e_fwd_val_reg;
    logic [iohist_pkg::COUNT_WIDTH-1:0] e_old;
    logic [iohist_pkg::COUNT_WIDTH-1:0] e_new;

    // Output register.
    logic                               m_valid_reg;
    logic                               m_counted_reg;
    logic [iohist_pkg::BIN_W-1:0]       m_bin_reg;
    logic [iohist_pkg::REPORT_W-1:0]    m_count_reg;
    logic [iohist_pkg::REPORT_W-1:0]    m_count_next;

    // Memory port control.
    logic                               take_e;
    logic                               adv_e;
    logic                               out_load;
    logic                               mem_we;
    logic [iohist_pkg::BIN_W-1:0]       mem_waddr;
    logic [iohist_pkg::COUNT_WIDTH-1:0] mem_wdata;

    assign out_load = !m_valid_reg || out_ready;
    assign adv_e    = e_valid_reg && out_load;
    assign in_ready = !e_valid_reg || out_load;
    assign take_e   = in_valid && in_ready;
    assign busy     = clearing_reg;

    // Increment with saturation; a matching write in flight overrides the read.
    always_comb begin
        e_old = e_fwd_reg ? e_fwd_val_reg : rd_data_reg;
        if (e_cnt_reg && (e_old != '1)) begin
            e_new = e_old + iohist_pkg::COUNT_WIDTH'(1);
        end else begin
            e_new = e_old;
        end
    end

    // Report the count clipped to the result width.
    always_comb begin
        if ((e_new >> iohist_pkg::REPORT_W) != '0) begin
            m_count_next = '1;
        end else begin
            m_count_next = iohist_pkg::REPORT_W'(e_new);
        end
    end

    // Write port: the clearing pass, then write-back of each item.
    always_comb begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = adv_e;
            mem_waddr = e_bin_reg;
            mem_wdata = e_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (take_e) begin
            rd_data_reg <= mem[in_item.bin];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            e_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                if (clr_addr_reg == iohist_pkg::BIN_W'(iohist_pkg::NUM_BINS - 1)) begin
                    clearing_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + iohist_pkg::BIN_W'(1);
                end
            end
            if (in_ready) e_valid_reg <= in_valid;
            if (out_load) m_valid_reg <= e_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (take_e) begin
            e_bin_reg     <= in_item.bin;
            e_cnt_reg     <= in_item.count_it;
            e_fwd_reg     <= adv_e && (e_bin_reg == in_item.bin);
            e_fwd_val_reg <= e_new;
        end
        if (adv_e) begin
            m_counted_reg <= e_cnt_reg;
            m_bin_reg     <= e_bin_reg;
            m_count_reg   <= m_count_next;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_counted = m_counted_reg;
    assign out_bin     = m_bin_reg;
    assign out_count   = m_count_reg;

endmodule

>>> hw/rtl/io_size_log_linear_histogram_core.sv
`timescale 1ns / 1ps

// Histogram of block I/O request sizes on a log-linear bin scale.
// Input channel (s_): one item per completed request. s_tdata carries the
// length in bytes, s_tuser says whether the request was seen at issue.
// Result channel (m_): exactly one item per input item, in order. It carries
// the chosen bin (0..99 one KiB each, 90 linear bins per decade above that,
// 460 for one million KiB or more), the bin's count after this item and
// whether this item counted (tracked request of nonzero length).
// Throughput is one item per cycle while the receiver keeps up: the counter
// memory is read as an item enters the read-modify-write stage and written
// back as it leaves it, and a write-back to the same bin is forwarded to
// the following item. From acceptance to m_tvalid an item passes six
// registers: four binning stages (decade select, reciprocal multiply,
// quotient correction, bin add), the memory read and the output register.
// After reset the counter memory is cleared one bin per cycle, with s_tready
// low. When the receiver stalls, the output register holds the result and
// the pipeline keeps accepting items until its stages are full; then
// s_tready drops. Counters saturate at their maximum value.
module io_size_log_linear_histogram_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] length_bytes
    input  logic        s_tuser,   // [0] request_known
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [8:0] bin_index, [40:9] bin_count, [47:41] zero
    output logic        m_tuser    // [0] counted
);

    logic                                   bin_in_ready;
    logic                                   bin_valid;
    logic                                   bin_ready;
    iohist_pkg::bin_item_t                  bin_item;
    logic                                   busy;
    logic [iohist_pkg::BIN_W-1:0]           out_bin;
    logic [iohist_pkg::REPORT_W-1:0]        out_count;

    // No items enter while the counters are being cleared.
    assign s_tready = bin_in_ready && !busy;

    iohist_binner u_binner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && !busy),
        .in_ready  (bin_in_ready),
        .in_length (s_tdata),
        .in_known  (s_tuser),
        .out_valid (bin_valid),
        .out_ready (bin_ready),
        .out_item  (bin_item)
    );

    iohist_counter u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (bin_valid),
        .in_ready    (bin_ready),
        .in_item     (bin_item),
        .busy        (busy),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_counted (m_tuser),
        .out_bin     (out_bin),
        .out_count   (out_count)
    );

    // Pack the result fields, low field first, zero padded.
    assign m_tdata = iohist_pkg::MDATA_W'({out_count, out_bin});

endmodule
